// ===== design/isf_pkg.sv =====
// Package for the identifier strip filter: payload types, control structs and character tests.
`default_nettype none

package isf_pkg;

    // Widths fixed by the payload and the configuration register
    localparam int OPCODE_W     = 2;
    localparam int CHAR_W       = 8;
    localparam int SLOT_W       = 4;
    localparam int POS_W        = 5;
    localparam int NAME_COUNT_W = 4;

    // Operation codes carried in the request
    localparam logic [OPCODE_W-1:0] OP_STREAM = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT         = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF         = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;

    // Input request
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   in_char;
        logic [SLOT_W-1:0]   name_slot;
        logic [POS_W-1:0]    char_pos;
    } t_in_item;

    // Output request
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_run;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_CHAR_WR
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load_name;
        logic append;
        logic overflow;
        logic finish_start;
        logic idx_inc;
        logic next_slot;
        logic emit_buf;
        logic emit_char;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_load;
        logic is_finish;
        logic is_ident_char;
        logic is_other;
        logic in_ident;
        logic pass;
        logic len_full;
        logic limit_zero;
        logic idx_at_end;
        logic name_zero;
        logic byte_eq;
        logic last_slot;
        logic emit_last;
        logic trailing;
        logic out_free;
    } t_status;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== design/isf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module isf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/isf_ctrl.sv =====
// Controller state machine of the identifier strip filter.
`default_nettype none

module isf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire isf_pkg::t_status i_status,
    output isf_pkg::t_cmd        o_cmd
);

    isf_pkg::t_state r_state;
    isf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            isf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = isf_pkg::ST_DECODE;
                end
            end
            isf_pkg::ST_DECODE: begin
                priority if (i_status.is_load) begin
                    o_cmd.load_name = 1'b1;
                    n_state         = isf_pkg::ST_IDLE;
                end else if (i_status.is_ident_char) begin
                    priority if (i_status.pass) begin
                        n_state = isf_pkg::ST_CHAR_WR;
                    end else if (!i_status.len_full) begin
                        o_cmd.append = 1'b1;
                        n_state      = isf_pkg::ST_IDLE;
                    end else begin
                        o_cmd.overflow = 1'b1;
                        n_state        = isf_pkg::ST_EMIT_RD;
                    end
                end else if (i_status.is_finish) begin
                    o_cmd.finish_start = 1'b1;
                    priority if (i_status.in_ident && !i_status.pass) begin
                        n_state = i_status.limit_zero ? isf_pkg::ST_EMIT_RD
                                                      : isf_pkg::ST_CMP_RD;
                    end else if (i_status.is_other) begin
                        n_state = isf_pkg::ST_CHAR_WR;
                    end else begin
                        n_state = isf_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = isf_pkg::ST_IDLE;
                end
            end
            isf_pkg::ST_CMP_RD: begin
                n_state = isf_pkg::ST_CMP_CHK;
            end
            isf_pkg::ST_CMP_CHK: begin
                priority if (i_status.idx_at_end && i_status.name_zero) begin
                    // Match: drop the identifier
                    n_state = i_status.trailing ? isf_pkg::ST_CHAR_WR : isf_pkg::ST_IDLE;
                end else if (!i_status.idx_at_end && i_status.byte_eq) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = isf_pkg::ST_CMP_RD;
                end else begin
                    // Mismatch: advance to the next name or emit
                    o_cmd.next_slot = 1'b1;
                    n_state = i_status.last_slot ? isf_pkg::ST_EMIT_RD : isf_pkg::ST_CMP_RD;
                end
            end
            isf_pkg::ST_EMIT_RD: begin
                n_state = isf_pkg::ST_EMIT_WR;
            end
            isf_pkg::ST_EMIT_WR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_buf = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = i_status.trailing ? isf_pkg::ST_CHAR_WR : isf_pkg::ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = isf_pkg::ST_EMIT_RD;
                    end
                end
            end
            isf_pkg::ST_CHAR_WR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    n_state         = isf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = isf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/isf_dpath.sv =====
// Datapath of the identifier strip filter: buffers, name table, counters and output register.
`default_nettype none

module isf_dpath #(
    parameter int NAME_SLOTS = 10,
    parameter int NAME_BYTES = 21
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire isf_pkg::t_in_item                   i_in_data,
    input  wire logic                                i_cfg_valid,
    input  wire logic [isf_pkg::NAME_COUNT_W-1:0]    i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output isf_pkg::t_out_item                       o_out_data,
    input  wire isf_pkg::t_cmd                       i_cmd,
    output isf_pkg::t_status                         o_status
);

    localparam int BUF_BYTES = NAME_BYTES - 1;
    localparam int BUF_AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int LEN_W     = $clog2(NAME_BYTES);
    localparam int TAB_DEPTH = NAME_SLOTS * NAME_BYTES;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int CW        = isf_pkg::CHAR_W;
    localparam int NCW       = isf_pkg::NAME_COUNT_W;

    isf_pkg::t_in_item  r_item;
    logic [NCW-1:0]     r_name_count;
    logic [LEN_W-1:0]   r_len;
    logic               r_in_ident;
    logic               r_pass;
    logic [LEN_W-1:0]   r_cnt;
    logic [LEN_W-1:0]   r_idx;
    logic               r_trailing;
    logic [NCW-1:0]     r_slot;
    logic [TAB_AW-1:0]  r_base;
    logic               r_out_valid;
    isf_pkg::t_out_item r_out_data;

    logic [NCW-1:0]    limit;
    logic [CW-1:0]     buf_rd;
    logic [CW-1:0]     name_rd;
    logic              load_ok;
    logic [TAB_AW-1:0] tab_wr_addr;
    logic [TAB_AW-1:0] tab_rd_addr;
    logic              is_stream;
    logic              blank;
    logic              ident_char;
    logic              out_free;

    // Classify the held request
    assign is_stream  = (r_item.opcode == isf_pkg::OP_STREAM);
    assign blank      = isf_pkg::is_blank(r_item.in_char);
    assign ident_char = is_stream && (isf_pkg::is_letter(r_item.in_char) ||
                        (isf_pkg::is_digit(r_item.in_char) && r_in_ident));

    // Saturate the name count to the table size
    assign limit = (32'(r_name_count) > NAME_SLOTS) ? NCW'(NAME_SLOTS) : r_name_count;

    // Name table addressing
    assign load_ok     = (32'(r_item.name_slot) < NAME_SLOTS) &&
                         (32'(r_item.char_pos) < NAME_BYTES);
    assign tab_wr_addr = TAB_AW'(32'(r_item.name_slot) * NAME_BYTES + 32'(r_item.char_pos));
    assign tab_rd_addr = TAB_AW'(32'(r_base) + 32'(r_idx));

    assign out_free = !r_out_valid || i_out_ready;

    isf_ram #(
        .WIDTH  (CW),
        .DEPTH  (BUF_BYTES),
        .ADDR_W (BUF_AW)
    ) u_ident_buf (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (r_len[BUF_AW-1:0]),
        .i_wr_data (r_item.in_char),
        .i_rd_addr (r_idx[BUF_AW-1:0]),
        .o_rd_data (buf_rd)
    );

    isf_ram #(
        .WIDTH  (CW),
        .DEPTH  (TAB_DEPTH),
        .ADDR_W (TAB_AW)
    ) u_name_tab (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load_name && load_ok),
        .i_wr_addr (tab_wr_addr),
        .i_wr_data (r_item.in_char),
        .i_rd_addr (tab_rd_addr),
        .o_rd_data (name_rd)
    );

    // Control registers: config, identifier state, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_count <= '0;
            r_len        <= '0;
            r_in_ident   <= 1'b0;
            r_pass       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_name_count <= i_cfg_data;
            end
            priority if (i_cmd.append) begin
                r_len      <= LEN_W'(r_len + LEN_W'(1));
                r_in_ident <= 1'b1;
            end else if (i_cmd.overflow) begin
                r_pass     <= 1'b1;
                r_in_ident <= 1'b1;
            end else if (i_cmd.finish_start) begin
                r_len      <= '0;
                r_in_ident <= 1'b0;
                r_pass     <= 1'b0;
            end else begin
                r_len <= r_len;
            end
            priority if (i_cmd.emit_buf || i_cmd.emit_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    // Payload registers: held request, counters, output data
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.overflow || i_cmd.finish_start) begin
            r_cnt      <= r_len;
            r_idx      <= '0;
            r_slot     <= '0;
            r_base     <= '0;
            r_trailing <= i_cmd.overflow || (is_stream && !blank);
        end else if (i_cmd.next_slot) begin
            r_idx  <= '0;
            r_slot <= NCW'(r_slot + NCW'(1));
            r_base <= TAB_AW'(32'(r_base) + NAME_BYTES);
        end else if (i_cmd.idx_inc) begin
            r_idx <= LEN_W'(r_idx + LEN_W'(1));
        end
        if (i_cmd.emit_buf) begin
            r_out_data.out_char    <= buf_rd;
            r_out_data.last_of_run <= o_status.emit_last && !r_trailing;
        end else if (i_cmd.emit_char) begin
            r_out_data.out_char    <= r_item.in_char;
            r_out_data.last_of_run <= 1'b1;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.is_load       = (r_item.opcode == isf_pkg::OP_LOAD);
        o_status.is_finish     = !ident_char && (is_stream ||
                                 (r_item.opcode == isf_pkg::OP_FLUSH));
        o_status.is_ident_char = ident_char;
        o_status.is_other      = is_stream && !blank && !ident_char;
        o_status.in_ident      = r_in_ident;
        o_status.pass          = r_pass;
        o_status.len_full      = (r_len == LEN_W'(BUF_BYTES));
        o_status.limit_zero    = (limit == '0);
        o_status.idx_at_end    = (r_idx == r_cnt);
        o_status.name_zero     = (name_rd == isf_pkg::CH_NUL);
        o_status.byte_eq       = (name_rd == buf_rd);
        o_status.last_slot     = ((NCW + 1)'(r_slot) + (NCW + 1)'(1)) == (NCW + 1)'(limit);
        o_status.emit_last     = (LEN_W'(r_idx + LEN_W'(1)) == r_cnt);
        o_status.trailing      = r_trailing;
        o_status.out_free      = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== design/identifier_strip_filter_core.sv =====
// Top level of the identifier strip filter: controller plus datapath.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | i_in_valid/o_in_ready  | i_in_data  (isf_pkg::t_in_item)
//   out     | output    | o_out_valid/i_out_ready| o_out_data (isf_pkg::t_out_item)
//   cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (name count, 4 bits)
//
// A buffered character or a table load passes through idle and decode; a byte
// that emits alone goes on to the character write state. Ending an identifier
// walks the loaded names through the name table RAM, a read and a check state per
// compared byte, then emits with a read and a write state per buffered byte. Reset
// is synchronous and needs no clearing pass. A stalled output holds the output
// register; a new request is taken when the controller is idle, even while the last result waits.
`default_nettype none

module identifier_strip_filter_core #(
    parameter int NAME_SLOTS = 10,
    parameter int NAME_BYTES = 21
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire isf_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output isf_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [isf_pkg::NAME_COUNT_W-1:0] i_cfg_data
);

    isf_pkg::t_cmd    cmd;
    isf_pkg::t_status status;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    isf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    isf_dpath #(
        .NAME_SLOTS (NAME_SLOTS),
        .NAME_BYTES (NAME_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

// ===== tb/isf_stream_checker.sv =====
// Output checker for the identifier strip filter: predicts the filtered bytes of every request.
module isf_stream_checker #(
    parameter int NAME_SLOTS = 10,
    parameter int NAME_BYTES = 21
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  isf_pkg::t_in_item                 i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  isf_pkg::t_out_item                i_out_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [isf_pkg::NAME_COUNT_W-1:0]  i_cfg_data,
    output int                                o_pending,
    output int                                o_errors,
    output int                                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import isf_pkg::*;

    localparam int WORD_MAX = NAME_BYTES - 1;

    // Mirror of the name table, the word being collected and the name count
    logic [CHAR_W-1:0]       names_mem [NAME_SLOTS][NAME_BYTES];
    logic [CHAR_W-1:0]       word_buf [WORD_MAX];
    int unsigned             word_len;
    bit                      word_open;
    bit                      word_spill;
    logic [NAME_COUNT_W-1:0] active_names;

    // Bytes still owed by the block, oldest first, and the bytes of one request
    t_out_item               expected_chars [$];
    t_out_item               request_chars [$];
    int                      err_count;
    int                      check_count;

    initial begin
        foreach (names_mem[s, p]) names_mem[s][p] = CH_NUL;
        foreach (word_buf[i]) word_buf[i] = CH_NUL;
        word_len     = 0;
        word_open    = 1'b0;
        word_spill   = 1'b0;
        active_names = '0;
        err_count    = 0;
        check_count  = 0;
        o_pending    = 0;
        o_errors     = 0;
        o_checked    = 0;
    end

    function automatic bit byte_is_letter(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c == "_");
    endfunction

    function automatic bit byte_is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit byte_is_blank(input logic [CHAR_W-1:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Compare the held word with every active name; a slot with no terminator never matches
    function automatic bit word_matches_name();
        int unsigned limit;
        int unsigned len;
        bit          same;
        bit          hit;
        hit   = 1'b0;
        limit = (active_names > NAME_SLOTS) ? NAME_SLOTS : active_names;
        for (int s = 0; s < limit; s++) begin
            len = 0;
            while (len < NAME_BYTES && names_mem[s][len] != CH_NUL) len++;
            if (len == word_len) begin
                same = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (names_mem[s][i] != word_buf[i]) same = 1'b0;
                end
                if (same) hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic queue_byte(input logic [CHAR_W-1:0] c);
        t_out_item r;
        r.out_char    = c;
        r.last_of_run = 1'b0;
        request_chars.push_back(r);
    endtask

    // End the pending word: emit it unless it spilled already or names a loaded entry
    task automatic close_word();
        if (word_open) begin
            if (!word_spill && !word_matches_name()) begin
                for (int i = 0; i < word_len; i++) queue_byte(word_buf[i]);
            end
            word_len   = 0;
            word_open  = 1'b0;
            word_spill = 1'b0;
        end
    endtask

    // Hold a word byte; on a full buffer dump it and pass the rest of the word through
    task automatic take_word_byte(input logic [CHAR_W-1:0] c);
        word_open = 1'b1;
        if (word_spill) begin
            queue_byte(c);
        end else if (word_len < WORD_MAX) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            foreach (word_buf[i]) queue_byte(word_buf[i]);
            word_spill = 1'b1;
            queue_byte(c);
        end
    endtask

    // Work out the output bytes of one accepted request and append them
    task automatic filter_request(input t_in_item req);
        request_chars.delete();
        case (req.opcode)
            OP_LOAD: begin
                if (req.name_slot < NAME_SLOTS && req.char_pos < NAME_BYTES)
                    names_mem[req.name_slot][req.char_pos] = req.in_char;
            end
            OP_FLUSH: begin
                close_word();
            end
            OP_STREAM: begin
                if (byte_is_blank(req.in_char)) begin
                    close_word();
                end else if (byte_is_letter(req.in_char) ||
                             (byte_is_digit(req.in_char) && word_open)) begin
                    take_word_byte(req.in_char);
                end else begin
                    close_word();
                    queue_byte(req.in_char);
                end
            end
            default: ;
        endcase
        if (request_chars.size() != 0)
            request_chars[request_chars.size() - 1].last_of_run = 1'b1;
        foreach (request_chars[i]) expected_chars.push_back(request_chars[i]);
    endtask

    // Check results first, then take the new name count and request of this edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result with none expected, actual out_char %02h last %0b",
                             $time, i_out_data.out_char, i_out_data.last_of_run);
                end else begin
                    want = expected_chars.pop_front();
                    check_count++;
                    if (i_out_data.out_char !== want.out_char) begin
                        err_count++;
                        $display("%0t ns: out_char expected %02h actual %02h",
                                 $time, want.out_char, i_out_data.out_char);
                    end
                    if (i_out_data.last_of_run !== want.last_of_run) begin
                        err_count++;
                        $display("%0t ns: last_of_run expected %0b actual %0b",
                                 $time, want.last_of_run, i_out_data.last_of_run);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) active_names = i_cfg_data;
            if (i_in_valid && i_in_ready) filter_request(i_in_data);
        end
        o_pending <= expected_chars.size();
        o_errors  <= err_count;
        o_checked <= check_count;
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the identifier strip filter: stimulus, handshake pacing and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import isf_pkg::*;

    localparam int NAME_SLOTS    = 10;
    localparam int NAME_BYTES    = 21;
    localparam int SETTLE_CYCLES = 600;     // full name walk plus a spilled word
    localparam int DRAIN_LIMIT   = 50000;
    localparam int PHASE_BUDGET  = 6;       // stream and flush requests per random phase
    localparam int NO_TERM_SLOT  = 6;       // slot filled to the brim, never matches
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_ready;
    t_in_item                req_data;
    logic                    res_valid;
    logic                    res_ready;
    t_out_item               res_data;
    logic                    cnt_valid;
    logic                    cnt_ready;
    logic [NAME_COUNT_W-1:0] cnt_data;

    int                      pending;
    int                      errors;
    int                      checked;
    int                      stream_count;
    int                      waited;
    bit                      steady;

    // What each slot currently holds, for sending words that hit a name
    logic [CHAR_W-1:0]       slot_text [NAME_SLOTS][NAME_BYTES];
    int                      slot_len [NAME_SLOTS];
    logic [NAME_COUNT_W-1:0] phase_counts [6];

    identifier_strip_filter_core #(
        .NAME_SLOTS (NAME_SLOTS),
        .NAME_BYTES (NAME_BYTES)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_valid (cnt_valid),
        .o_cfg_ready (cnt_ready),
        .i_cfg_data  (cnt_data)
    );

    isf_stream_checker #(
        .NAME_SLOTS (NAME_SLOTS),
        .NAME_BYTES (NAME_BYTES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_ready  (req_ready),
        .i_in_data   (req_data),
        .i_out_valid (res_valid),
        .i_out_ready (res_ready),
        .i_out_data  (res_data),
        .i_cfg_valid (cnt_valid),
        .i_cfg_ready (cnt_ready),
        .i_cfg_data  (cnt_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #15_000_000;
        $display("identifier_strip_filter_core verification failed");
        $finish;
    end

    // Drop ready for a random stall before each result, none in steady stretches
    initial begin
        int stall;
        res_ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    function automatic t_in_item make_req(input logic [OPCODE_W-1:0] op,
                                          input logic [CHAR_W-1:0] c,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [POS_W-1:0] pos);
        t_in_item r;
        r.opcode    = op;
        r.in_char   = c;
        r.name_slot = slot;
        r.char_pos  = pos;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_lead();
        case ($urandom_range(0, 2))
            0: return 8'(CH_UPPER_A + $urandom_range(0, 25));
            1: return 8'(CH_LOWER_A + $urandom_range(0, 25));
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_tail();
        if ($urandom_range(0, 3) == 0) return 8'(CH_DIGIT_0 + $urandom_range(0, 9));
        return pick_lead();
    endfunction

    // A byte that ends a word: whitespace, punctuation, a high byte or a control byte
    function automatic logic [CHAR_W-1:0] pick_sep();
        string punct;
        punct = "+-*/;,.(){}[]<>=!&|#%^~?:@$";
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                case ($urandom_range(0, 5))
                    0: return CH_SPACE;
                    1: return CH_TAB;
                    2: return CH_LF;
                    3: return CH_VT;
                    4: return CH_FF;
                    default: return CH_CR;
                endcase
            end
            3, 4, 5: return punct[$urandom_range(0, punct.len() - 1)];
            6: return 8'($urandom_range(128, 255));
            default: begin
                case ($urandom_range(0, 2))
                    0: return 8'($urandom_range(0, 8));
                    1: return 8'($urandom_range(14, 31));
                    default: return 8'h7F;
                endcase
            end
        endcase
    endfunction

    // Present one request after a random gap and hold it until the block takes it
    task automatic push_request(input t_in_item req);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        push_request(make_req(OP_STREAM, c, 4'($urandom), 5'($urandom)));
        stream_count++;
    endtask

    task automatic send_flush();
        push_request(make_req(OP_FLUSH, 8'($urandom), 4'($urandom), 5'($urandom)));
        stream_count++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_char(t[i]);
    endtask

    task automatic send_word(input int len);
        send_char(pick_lead());
        for (int i = 1; i < len; i++) send_char(pick_tail());
    endtask

    function automatic void set_slot_text(input int slot, input string t);
        slot_len[slot] = t.len();
        for (int p = 0; p < NAME_BYTES; p++)
            slot_text[slot][p] = (p < t.len()) ? t[p] : CH_NUL;
    endfunction

    // Write a slot's name up to and including its terminator; a compare never reads past it
    task automatic load_slot(input int slot);
        for (int p = 0; p <= slot_len[slot] && p < NAME_BYTES; p++)
            push_request(make_req(OP_LOAD, slot_text[slot][p], 4'(slot), 5'(p)));
    endtask

    task automatic load_random_name(input int slot);
        int len;
        len = ($urandom_range(0, 7) == 0) ? NAME_BYTES - 1 : $urandom_range(1, 6);
        slot_len[slot] = len;
        for (int p = 0; p < NAME_BYTES; p++) begin
            if (p == 0) slot_text[slot][p] = pick_lead();
            else if (p < len) slot_text[slot][p] = pick_tail();
            else slot_text[slot][p] = CH_NUL;
        end
        load_slot(slot);
    endtask

    // Stop requests, wait for every owed result, then let the block go quiet
    task automatic settle(input int extra);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_count(input logic [NAME_COUNT_W-1:0] value);
        cnt_valid <= 1'b1;
        cnt_data  <= value;
        @(posedge clk);
        while (!cnt_ready) @(posedge clk);
        cnt_valid <= 1'b0;
    endtask

    // Mostly well-formed tokens: names, fresh words, numbers, separators; some noise
    task automatic random_stream(input int budget);
        int stop;
        int pick;
        int slot;
        int len;
        stop = stream_count + budget;
        while (stream_count < stop) begin
            if ($urandom_range(0, 9) == 0) steady = !steady;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                slot = $urandom_range(0, NAME_SLOTS - 1);
                for (int i = 0; i < slot_len[slot]; i++) send_char(slot_text[slot][i]);
                send_char(pick_sep());
            end else if (pick < 65) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 8);
                send_word(len);
                if ($urandom_range(0, 4) == 0) send_flush();
                else send_char(pick_sep());
            end else if (pick < 73) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) send_char(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
                send_char(pick_sep());
            end else if (pick < 85) begin
                send_char(pick_sep());
            end else if (pick < 89) begin
                send_char(8'($urandom));
            end else if (pick < 93) begin
                send_flush();
            end else if (pick < 96) begin
                push_request(make_req(OP_UNUSED, 8'($urandom), 4'($urandom), 5'($urandom)));
            end else if ($urandom_range(0, 1) == 0) begin
                push_request(make_req(OP_LOAD, 8'($urandom), 4'($urandom_range(10, 15)),
                                      5'($urandom)));
            end else begin
                push_request(make_req(OP_LOAD, 8'($urandom), 4'($urandom_range(0, 9)),
                                      5'($urandom_range(21, 31))));
            end
        end
    endtask

    initial begin
        req_valid    <= 1'b0;
        req_data     <= '0;
        cnt_valid    <= 1'b0;
        cnt_data     <= '0;
        rst_n        <= 1'b0;
        steady       = 1'b0;
        stream_count = 0;
        phase_counts = '{4'd0, 4'd15, 4'd1, 4'd6, 4'd2, 4'd10};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every name before any compare can run
        set_slot_text(0, "int");
        set_slot_text(1, "for");
        set_slot_text(2, "x");
        set_slot_text(3, "while");
        set_slot_text(4, "_tmp");
        set_slot_text(5, "abcdefghijklmnopqrst");
        set_slot_text(NO_TERM_SLOT, "abcdefghijklmnopqrstu");
        set_slot_text(7, "return");
        set_slot_text(8, "Zz9");
        set_slot_text(9, "q_");
        for (int s = 0; s < NAME_SLOTS; s++) load_slot(s);
        settle(SETTLE_CYCLES);
        write_count(4'd10);

        // Matched names drop out, near misses and digits inside words pass
        send_text("int");
        send_char(CH_SPACE);
        send_text("intx");
        send_char(";");
        send_text("x1");
        send_char(CH_TAB);
        send_text("_tmp");
        send_char(CH_LF);
        // Longest name that fits the buffer, then a word that spills past it
        send_text("abcdefghijklmnopqrst");
        send_char(CH_CR);
        send_text("abcdefghijklmnopqrstuv");
        send_char(CH_VT);
        // Lone digit, high bytes, zero byte, form feed
        send_char("7");
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CH_NUL);
        send_char(CH_FF);
        // Flush a matching word, a plain word, and nothing at all
        send_text("Zz9");
        send_flush();
        send_text("q");
        send_flush();
        send_flush();
        // Unused opcode and loads outside the table leave everything alone
        push_request(make_req(OP_UNUSED, 8'hFF, 4'hF, 5'h1F));
        push_request(make_req(OP_LOAD, 8'hFF, 4'hF, 5'h1F));
        push_request(make_req(OP_LOAD, 8'h41, 4'd10, 5'd0));
        push_request(make_req(OP_LOAD, 8'h41, 4'd0, 5'd21));
        send_text("int");
        send_char("+");

        // Random phases over several name counts, reloading one slot each time
        foreach (phase_counts[k]) begin
            settle(SETTLE_CYCLES);
            write_count((k == 4) ? 4'($urandom_range(2, 9)) : phase_counts[k]);
            load_random_name(($urandom_range(0, NAME_SLOTS - 2) + NO_TERM_SLOT + 1)
                             % NAME_SLOTS);
            random_stream(PHASE_BUDGET);
        end

        // Wait out every owed result, then give stray output time to show up
        req_valid <= 1'b0;
        steady = 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d stream and flush requests at name counts 0, 1, 10, 15 and others,",
                 stream_count);
        $display("with matches, spills and flushes; %0d bytes compared, %0d never arrived.",
                 checked, pending);
        if (errors == 0 && pending == 0) begin
            $display("identifier_strip_filter_core verification clean");
        end else begin
            $display("identifier_strip_filter_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/isf_pkg.sv
design/isf_ram.sv
design/isf_ctrl.sv
design/isf_dpath.sv
design/identifier_strip_filter_core.sv
tb/isf_stream_checker.sv
tb/testbench.sv
